>>> rtl/core/tlvp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, field table and types for the TLV record parser.
package tlvp_pkg;

    localparam int NUM_FIELDS = 34;
    localparam int IDX_W      = 6;

    // Parse phase codes
    localparam logic [1:0] PH_TAG = 2'd0;
    localparam logic [1:0] PH_LEN = 2'd1;
    localparam logic [1:0] PH_VAL = 2'd2;

    // Section codes
    localparam logic [1:0] SEC_UNK = 2'd0;
    localparam logic [1:0] SEC_CUR = 2'd1;
    localparam logic [1:0] SEC_DEF = 2'd2;

    // Tag that selects the section
    localparam logic [7:0] TAG_SECTION = 8'h00;

    typedef struct packed {
        logic [7:0] tag;
        logic [2:0] len;
    } t_field_desc;

    // Position in the table is the dense field index.
    localparam t_field_desc FIELD_TABLE [NUM_FIELDS] = '{
        '{8'h10, 3'd2}, '{8'h11, 3'd2}, '{8'h12, 3'd4}, '{8'h20, 3'd2}, '{8'h1F, 3'd1},
        '{8'h13, 3'd4}, '{8'h14, 3'd4}, '{8'h16, 3'd4}, '{8'h40, 3'd1}, '{8'h49, 3'd2},
        '{8'h30, 3'd2}, '{8'h31, 3'd2}, '{8'h32, 3'd2}, '{8'h33, 3'd1}, '{8'h34, 3'd1},
        '{8'h35, 3'd2}, '{8'h36, 3'd2}, '{8'h37, 3'd2}, '{8'h38, 3'd2}, '{8'h39, 3'd1},
        '{8'h41, 3'd1}, '{8'h42, 3'd1}, '{8'h43, 3'd1}, '{8'h44, 3'd1}, '{8'h45, 3'd1},
        '{8'h46, 3'd1}, '{8'h47, 3'd1}, '{8'h48, 3'd1}, '{8'h4A, 3'd1}, '{8'h4B, 3'd1},
        '{8'h4C, 3'd1}, '{8'h01, 3'd1}, '{8'h02, 3'd4}, '{8'h03, 3'd4}
    };

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_lookup;

    typedef struct packed {
        logic             upd;
        logic [IDX_W-1:0] idx;
        logic [31:0]      value;
        logic             blk_end;
        logic             blk_changed;
    } t_result;

endpackage

>>> rtl/core/tlvp_field_lookup.sv
`timescale 1ns / 1ps
// Known-tag table match: tag and exact length to dense field index.
module tlvp_field_lookup (
    input  logic [7:0]       i_tag,
    input  logic [7:0]       i_len,
    output tlvp_pkg::t_lookup o_lookup
);
    import tlvp_pkg::*;

    logic             found;
    logic             len_ok;
    logic [IDX_W-1:0] idx;

    // Walk downward so the lowest matching entry wins.
    always_comb begin
        found  = 1'b0;
        len_ok = 1'b0;
        idx    = '0;
        for (int i = NUM_FIELDS - 1; i >= 0; i--) begin
            if (FIELD_TABLE[i].tag == i_tag) begin
                found  = 1'b1;
                len_ok = (i_len == {5'd0, FIELD_TABLE[i].len});
                idx    = IDX_W'(i);
            end
        end
    end

    assign o_lookup.hit = found && len_ok;
    assign o_lookup.idx = idx;

endmodule

>>> rtl/core/tlvp_parse_core.sv
`timescale 1ns / 1ps
// Record state machine, value assembly, section tracking and result build.
module tlvp_parse_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_data_byte,
    input  logic              i_block_last,
    output logic              o_has_result,
    output tlvp_pkg::t_result o_res
);
    import tlvp_pkg::*;

    logic [1:0]  r_phase,   n_phase;
    logic [7:0]  r_tag,     n_tag;
    logic [7:0]  r_len,     n_len;
    logic [7:0]  r_seen,    n_seen;
    logic [31:0] r_acc,     n_acc;
    logic [7:0]  r_first,   n_first;
    logic [1:0]  r_section, n_section;
    logic        r_changed, n_changed;

    logic        finish;
    logic        upd;
    logic [7:0]  seen_inc;
    logic [7:0]  rec_len;
    t_lookup     lookup;

    // Length of the record being closed: the length byte itself on a zero-length record.
    assign rec_len = (r_phase == PH_LEN) ? i_data_byte : r_len;

    tlvp_field_lookup u_lookup (
        .i_tag    (r_tag),
        .i_len    (rec_len),
        .o_lookup (lookup)
    );

    assign seen_inc = r_seen + 8'd1;

    always_comb begin
        n_phase   = r_phase;
        n_tag     = r_tag;
        n_len     = r_len;
        n_seen    = r_seen;
        n_acc     = r_acc;
        n_first   = r_first;
        n_section = r_section;
        finish    = 1'b0;
        unique case (r_phase)
            PH_LEN: begin
                n_len   = i_data_byte;
                n_seen  = '0;
                n_acc   = '0;
                n_first = '0;
                if (i_data_byte == 8'd0) begin
                    finish = 1'b1;
                end else begin
                    n_phase = PH_VAL;
                end
            end
            PH_VAL: begin
                if (r_seen == 8'd0) begin
                    n_first = i_data_byte;
                end
                n_acc  = {r_acc[23:0], i_data_byte};
                n_seen = seen_inc;
                finish = (seen_inc == r_len);
            end
            default: begin
                n_tag   = i_data_byte;
                n_phase = PH_LEN;
            end
        endcase

        upd = 1'b0;
        if (finish) begin
            n_phase = PH_TAG;
            if (r_tag == TAG_SECTION && n_len != 8'd0) begin
                priority if (n_first == 8'd1) begin
                    n_section = SEC_CUR;
                end else if (n_first == 8'd2) begin
                    n_section = SEC_DEF;
                end else begin
                    n_section = SEC_UNK;
                end
            end else begin
                upd = (r_section == SEC_CUR) && lookup.hit;
            end
        end

        n_changed = r_changed | upd;

        o_res.upd         = upd;
        o_res.idx         = upd ? lookup.idx : '0;
        o_res.value       = upd ? n_acc : '0;
        o_res.blk_end     = i_block_last;
        o_res.blk_changed = i_block_last && n_changed;
        o_has_result      = upd || i_block_last;

        // Drop any partial record at block end; section persists.
        if (i_block_last) begin
            n_phase   = PH_TAG;
            n_tag     = '0;
            n_len     = '0;
            n_seen    = '0;
            n_acc     = '0;
            n_first   = '0;
            n_changed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TAG;
            r_tag     <= '0;
            r_len     <= '0;
            r_seen    <= '0;
            r_acc     <= '0;
            r_first   <= '0;
            r_section <= SEC_CUR;
            r_changed <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_tag     <= n_tag;
            r_len     <= n_len;
            r_seen    <= n_seen;
            r_acc     <= n_acc;
            r_first   <= n_first;
            r_section <= n_section;
            r_changed <= n_changed;
        end
    end

    a_upd_needs_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.upd |-> (r_section == SEC_CUR))
        else $error("update outside current section");

    a_upd_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.upd |-> (o_res.idx < IDX_W'(NUM_FIELDS)))
        else $error("field index out of range");

    a_changed_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.blk_changed |-> o_res.blk_end)
        else $error("block_changed without block end");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_block_last) |=> (r_phase == PH_TAG && !r_changed))
        else $error("record state not cleared after block end");

    a_update_sets_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.upd && !i_block_last) |=> r_changed)
        else $error("update did not mark block changed");

endmodule

>>> rtl/core/tlv_config_record_parser_unit.sv
`timescale 1ns / 1ps
// Top level of the TLV configuration record parser: input and result registers around the core.
// An accepted byte waits in the input register, passes through the core when that register
//   advances, and its result, if any, is loaded into the output register that drives o_valid.
// Throughput: one byte per cycle, result or not, unless i_stall holds a full output register.
// The input register advances only when the output register is empty or being drained.
// Reset (i_rst_n low, synchronous) empties both registers, sets the parser to expect a tag
//   and selects the current section.
module tlv_config_record_parser_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_block_last,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_update_valid,
    output logic [tlvp_pkg::IDX_W-1:0] o_field_index,
    output logic [31:0]               o_field_value,
    output logic                      o_block_end,
    output logic                      o_block_changed
);
    import tlvp_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_vld;
    t_result    r_out;

    logic       out_free;
    logic       adv;
    logic       accept;
    logic       has_result;
    t_result    res;

    assign out_free = !r_out_vld || !i_stall;
    assign adv      = r_in_vld && out_free;
    assign o_stall  = r_in_vld && !out_free;
    assign accept   = i_valid && !o_stall;

    tlvp_parse_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (adv),
        .i_data_byte  (r_in_byte),
        .i_block_last (r_in_last),
        .o_has_result (has_result),
        .o_res        (res)
    );

    // Input register: load on transfer, drop once consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_block_last;
        end
    end

    // Result register: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && has_result) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && has_result) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_update_valid  = r_out.upd;
    assign o_field_index   = r_out.idx;
    assign o_field_value   = r_out.value;
    assign o_block_end     = r_out.blk_end;
    assign o_block_changed = r_out.blk_changed;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the TLV configuration record parser unit.
module testbench;
    import tlvp_pkg::*;

    localparam logic [7:0] SEL_CURRENT_BYTE  = 8'h01;
    localparam logic [7:0] SEL_DEFAULTS_BYTE = 8'h02;
    localparam int         LONG_HOLD_CYCLES  = 80;
    localparam int         MAX_PRINTED       = 40;

    // Known tags and their exact value lengths; position is the field index.
    localparam logic [7:0] KNOWN_TAG [NUM_FIELDS] = '{
        8'h10, 8'h11, 8'h12, 8'h20, 8'h1F, 8'h13, 8'h14, 8'h16, 8'h40, 8'h49,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
        8'h4C, 8'h01, 8'h02, 8'h03
    };
    localparam int KNOWN_LEN [NUM_FIELDS] = '{
        2, 2, 4, 2, 1, 4, 4, 4, 1, 2,
        2, 2, 2, 1, 1, 2, 2, 2, 2, 1,
        1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
        1, 1, 4, 4
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [7:0]        i_data_byte;
    logic              i_block_last;
    logic              o_valid;
    logic              i_stall;
    logic              o_update_valid;
    logic [IDX_W-1:0]  o_field_index;
    logic [31:0]       o_field_value;
    logic              o_block_end;
    logic              o_block_changed;

    tlv_config_record_parser_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_block_last    (i_block_last),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_update_valid  (o_update_valid),
        .o_field_index   (o_field_index),
        .o_field_value   (o_field_value),
        .o_block_end     (o_block_end),
        .o_block_changed (o_block_changed)
    );

    // Parser state as the testbench tracks it
    logic [1:0]  rx_phase;
    logic [7:0]  rx_tag;
    logic [7:0]  rx_len;
    logic [7:0]  rx_seen;
    logic [31:0] rx_acc;
    logic [7:0]  rx_first;
    logic [1:0]  rx_section;
    bit          rx_changed;

    t_result     expected_results[$];
    logic [7:0]  block_bytes[$];
    int          error_count = 0;
    int          bytes_sent  = 0;
    int          hold_reqs   = 0;
    bit          src_offering = 0;
    bit          src_busy    = 0;
    bit          sink_free   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED)
            $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic close_record(output bit hit, output logic [IDX_W-1:0] idx);
        hit = 1'b0;
        idx = '0;
        rx_phase = PH_TAG;
        if (rx_tag == TAG_SECTION && rx_len >= 1) begin
            case (rx_first)
                SEL_CURRENT_BYTE:  rx_section = SEC_CUR;
                SEL_DEFAULTS_BYTE: rx_section = SEC_DEF;
                default:           rx_section = SEC_UNK;
            endcase
        end else if (rx_section == SEC_CUR) begin
            // first entry with a matching tag decides; length must match exactly
            for (int k = 0; k < NUM_FIELDS; k++) begin
                if (KNOWN_TAG[k] == rx_tag) begin
                    hit = (KNOWN_LEN[k] == rx_len);
                    idx = IDX_W'(k);
                    break;
                end
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input bit last);
        bit               hit;
        logic [IDX_W-1:0] idx;
        t_result          r;
        hit = 1'b0;
        idx = '0;
        case (rx_phase)
            PH_LEN: begin
                rx_len   = b;
                rx_seen  = '0;
                rx_acc   = '0;
                rx_first = '0;
                if (b == 8'd0)
                    close_record(hit, idx);
                else
                    rx_phase = PH_VAL;
            end
            PH_VAL: begin
                if (rx_seen == 8'd0)
                    rx_first = b;
                rx_acc  = {rx_acc[23:0], b};
                rx_seen = rx_seen + 8'd1;
                if (rx_seen == rx_len)
                    close_record(hit, idx);
            end
            default: begin
                rx_tag   = b;
                rx_phase = PH_LEN;
            end
        endcase
        if (hit)
            rx_changed = 1'b1;
        if (hit || last) begin
            r.upd         = hit;
            r.idx         = hit ? idx : '0;
            r.value       = hit ? rx_acc : '0;
            r.blk_end     = last;
            r.blk_changed = last && rx_changed;
            expected_results.push_back(r);
        end
        if (last) begin
            // a truncated record is dropped; the section choice stays
            rx_phase   = PH_TAG;
            rx_tag     = '0;
            rx_len     = '0;
            rx_seen    = '0;
            rx_acc     = '0;
            rx_first   = '0;
            rx_changed = 1'b0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_block_last <= last;
        src_offering = 1'b1;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predict_byte(b, last);
        bytes_sent++;
        gap = src_busy ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            src_offering = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic src_stop();
        if (src_offering) begin
            i_valid <= 1'b0;
            src_offering = 1'b0;
        end
    endtask

    task automatic send_block();
        for (int k = 0; k < block_bytes.size(); k++)
            send_byte(block_bytes[k], k == block_bytes.size() - 1);
    endtask

    task automatic wait_drain();
        src_stop();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_value_byte(input bit selects_section);
        int r;
        r = $urandom_range(0, 99);
        if (selects_section) begin
            if (r < 60) return SEL_CURRENT_BYTE;
            if (r < 85) return SEL_DEFAULTS_BYTE;
            return 8'($urandom_range(0, 255));
        end
        if (r < 10) return 8'h00;
        if (r < 20) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_record();
        int         kind;
        int         i;
        int         len;
        logic [7:0] tag;
        bit         known;
        kind = $urandom_range(0, 99);
        if (kind < 62) begin
            i   = $urandom_range(0, NUM_FIELDS - 1);
            tag = KNOWN_TAG[i];
            len = KNOWN_LEN[i];
        end else if (kind < 72) begin
            tag = TAG_SECTION;
            len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
        end else if (kind < 82) begin
            i   = $urandom_range(0, NUM_FIELDS - 1);
            tag = KNOWN_TAG[i];
            do len = $urandom_range(0, 6); while (len == KNOWN_LEN[i]);
        end else if (kind < 94) begin
            do begin
                tag   = 8'($urandom_range(0, 255));
                known = (tag == TAG_SECTION);
                foreach (KNOWN_TAG[k])
                    if (KNOWN_TAG[k] == tag) known = 1'b1;
            end while (known);
            len = $urandom_range(0, 6);
        end else if (kind < 99) begin
            tag = 8'($urandom_range(0, 255));
            len = $urandom_range(5, 12);
        end else begin
            tag = 8'($urandom_range(0, 255));
            len = $urandom_range(13, 255);
        end
        block_bytes.push_back(tag);
        block_bytes.push_back(8'(len));
        for (int k = 0; k < len; k++)
            block_bytes.push_back(pick_value_byte(tag == TAG_SECTION && k == 0));
    endtask

    task automatic build_block();
        int n;
        int cut;
        block_bytes.delete();
        if ($urandom_range(0, 19) == 0) begin
            // noise: random bytes with no structure
            n = $urandom_range(1, 12);
            repeat (n) block_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        n = $urandom_range(1, 5);
        repeat (n) add_record();
        if ($urandom_range(0, 9) == 0 && block_bytes.size() > 1) begin
            cut = $urandom_range(1, block_bytes.size() - 1);
            repeat (cut) void'(block_bytes.pop_back());
        end
    endtask

    // Receiver: random stall runs, plus a long hold on request.
    initial begin
        int run_left;
        bit run_level;
        int holds_done;
        int hold_left;
        run_left   = 0;
        run_level  = 1'b0;
        holds_done = 0;
        hold_left  = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != holds_done) begin
                holds_done = hold_reqs;
                hold_left  = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (sink_free) begin
                run_left = 0;
                i_stall <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    run_level = ($urandom_range(0, 99) < 30);
                    if (!run_level)
                        run_left = $urandom_range(1, 20);
                    else if ($urandom_range(0, 19) == 0)
                        run_left = $urandom_range(10, 30);
                    else
                        run_left = $urandom_range(1, 3);
                end
                run_left--;
                i_stall <= run_level;
            end
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
                report_error($sformatf("unexpected result upd=%0b idx=%0d value=%h end=%0b",
                             o_update_valid, o_field_index, o_field_value, o_block_end));
            end else begin
                e = expected_results.pop_front();
                if (o_update_valid !== e.upd)
                    report_error($sformatf("update_valid %0b, expected %0b",
                                 o_update_valid, e.upd));
                if (o_field_index !== e.idx)
                    report_error($sformatf("field_index %0d, expected %0d",
                                 o_field_index, e.idx));
                if (o_field_value !== e.value)
                    report_error($sformatf("field_value %h, expected %h",
                                 o_field_value, e.value));
                if (o_block_end !== e.blk_end)
                    report_error($sformatf("block_end %0b, expected %0b",
                                 o_block_end, e.blk_end));
                if (o_block_changed !== e.blk_changed)
                    report_error($sformatf("block_changed %0b, expected %0b",
                                 o_block_changed, e.blk_changed));
            end
        end
    end

    task automatic test_directed_records();
        // all-ones 4-byte value, then an update on the block's last byte
        block_bytes = '{KNOWN_TAG[2], 8'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                        KNOWN_TAG[4], 8'd1, 8'h00};
        send_block();
        // section tag with zero length, wrong length, defaults section skips a
        // known field, back to current, then a record cut off at its tag byte
        block_bytes = '{TAG_SECTION, 8'd0,
                        KNOWN_TAG[0], 8'd1, 8'h55,
                        TAG_SECTION, 8'd1, SEL_DEFAULTS_BYTE,
                        KNOWN_TAG[0], 8'd2, 8'h12, 8'h34,
                        TAG_SECTION, 8'd1, SEL_CURRENT_BYTE,
                        KNOWN_TAG[31]};
        send_block();
    endtask

    task automatic test_random_blocks(input int byte_goal);
        int r;
        while (bytes_sent < byte_goal) begin
            r = $urandom_range(0, 29);
            if (r == 0) src_busy = 1'b1;
            else if (r < 4) src_busy = 1'b0;
            r = $urandom_range(0, 29);
            if (r == 0) sink_free = 1'b1;
            else if (r < 4) sink_free = 1'b0;
            if ($urandom_range(0, 24) == 0)
                wait_drain();
            build_block();
            send_block();
        end
        src_busy  = 1'b0;
        sink_free = 1'b0;
    endtask

    task automatic test_back_pressure();
        // hold the receiver while updates stream in back to back
        hold_reqs++;
        src_busy = 1'b1;
        block_bytes = '{TAG_SECTION, 8'd1, SEL_CURRENT_BYTE};
        repeat (15) begin
            block_bytes.push_back(KNOWN_TAG[8]);
            block_bytes.push_back(8'd1);
            block_bytes.push_back(8'($urandom_range(0, 255)));
        end
        send_block();
        src_busy = 1'b0;
    endtask

    task automatic test_drain_pause();
        wait_drain();
        build_block();
        send_block();
        wait_drain();
    endtask

    task automatic test_bursts();
        // no idling on either side
        src_busy  = 1'b1;
        sink_free = 1'b1;
        repeat (6) begin
            build_block();
            send_block();
        end
        src_busy  = 1'b0;
        sink_free = 1'b0;
    endtask

    initial begin
        rx_phase   = PH_TAG;
        rx_tag     = '0;
        rx_len     = '0;
        rx_seen    = '0;
        rx_acc     = '0;
        rx_first   = '0;
        rx_section = SEC_CUR;
        rx_changed = 1'b0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_data_byte  <= '0;
        i_block_last <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_records();
        test_random_blocks(450);
        test_back_pressure();
        test_bursts();
        test_drain_pause();
        test_random_blocks(900);

        src_stop();
        for (int k = 0; k < 5000 && expected_results.size() != 0; k++)
            @(posedge i_clk);
        if (expected_results.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_results.size()));
        repeat (4) @(posedge i_clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
